// File: hw/rtl/rau_pkg.sv
// Package for the rational accumulator unit.
// Holds the operation codes, field widths, state types and the control struct of the shared unit.
// No dependencies.
package rau_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned EXT_W   = 64;
  localparam int unsigned KIND_W  = 3;

  localparam logic [KIND_W-1:0] KIND_LOAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_GCD
  } alu_op_e;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_GCD,
    A_GSHL,
    A_DONE
  } alu_st_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_D,
    ST_ADD_GCD,
    ST_ADD_DIV1,
    ST_ADD_LCM,
    ST_ADD_Q1,
    ST_ADD_T1,
    ST_ADD_Q2,
    ST_ADD_T2,
    ST_ADD_SUM,
    ST_RED_CHK,
    ST_RED_GCD,
    ST_RED_DN,
    ST_RED_DD,
    ST_FINISH
  } rau_st_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

endpackage

// File: hw/rtl/rational_accumulator_unit.sv
// Rational accumulator unit: load, add, subtract, multiply and divide transfers on a signed
// fraction, gcd-reduced after each one. Depends on rau_pkg and rau_alu. W = WORD_WIDTH.
// Products, quotients and gcds run on the shared rau_alu. A zero numerator skips the reduction
// and an unknown kind goes straight to the output, leaving the accumulator unchanged. The next
// input is taken only after the result is registered. Reset: accumulator 0 / 1, output empty.
module rational_accumulator_unit import rau_pkg::*; #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [2*FIELD_W-1:0] s_axis_tdata_i,   // operand_num, operand_den
  input  logic [KIND_W-1:0]    s_axis_tuser_i,   // kind
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [2*FIELD_W-1:0] m_axis_tdata_o    // result_num, result_den
);

  localparam int unsigned W = WORD_WIDTH;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (W'(0) - v) : v;
  endfunction

  rau_st_e             st_q, st_d;
  logic                issued_q;
  logic [KIND_W-1:0]   kind_q;
  logic [W-1:0]        on_q, od_q, n_q, d_q, t_q, g_q;
  logic [W-1:0]        acc_num_q, acc_den_q;
  logic                m_valid_q;
  logic [FIELD_W-1:0]  m_num_q, m_den_q;

  logic                s_fire, out_free, call_st;
  logic [EXT_W-1:0]    in_num_ext, in_den_ext, out_num_ext, out_den_ext;
  logic [W-1:0]        in_num, in_den, in_den_fix;
  alu_ctl_t            alu_ctl;
  logic [W-1:0]        alu_x, alu_y, alu_res, alu_neg;
  logic                alu_done;

  assign in_num_ext  = EXT_W'(signed'(s_axis_tdata_i[FIELD_W-1:0]));
  assign in_den_ext  = EXT_W'(signed'(s_axis_tdata_i[2*FIELD_W-1:FIELD_W]));
  assign in_num      = in_num_ext[W-1:0];
  assign in_den      = in_den_ext[W-1:0];
  assign in_den_fix  = ((s_axis_tuser_i == KIND_LOAD || s_axis_tuser_i == KIND_ADD ||
                         s_axis_tuser_i == KIND_SUB) && in_den == '0) ? W'(1) : in_den;
  assign out_num_ext = EXT_W'(signed'(acc_num_q));
  assign out_den_ext = EXT_W'(signed'(acc_den_q));

  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_den_q, m_num_q};
  assign alu_neg         = W'(0) - alu_res;

  rau_alu #(
    .WORD_WIDTH(W)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (alu_ctl),
    .x_i   (alu_x),
    .y_i   (alu_y),
    .done_o(alu_done),
    .res_o (alu_res)
  );

  always_comb begin
    s_axis_tready_o = 1'b0;
    call_st         = 1'b1;
    alu_ctl.op      = ALU_MUL;
    alu_x           = acc_num_q;
    alu_y           = on_q;
    unique case (st_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        call_st         = 1'b0;
      end
      ST_MUL_N: begin
        alu_y = (kind_q == KIND_MUL) ? on_q : od_q;
      end
      ST_MUL_D: begin
        alu_x = acc_den_q;
        alu_y = (kind_q == KIND_MUL) ? od_q : on_q;
      end
      ST_ADD_GCD: begin
        alu_ctl.op = ALU_GCD;
        alu_x      = mag(acc_den_q);
        alu_y      = mag(od_q);
      end
      ST_ADD_DIV1: begin
        alu_ctl.op = ALU_DIV;
        alu_x      = mag(acc_den_q);
        alu_y      = g_q;
      end
      ST_ADD_LCM: begin
        alu_x = t_q;
        alu_y = mag(od_q);
      end
      ST_ADD_Q1: begin
        alu_ctl.op = ALU_DIV;
        alu_x      = mag(d_q);
        alu_y      = mag(acc_den_q);
      end
      ST_ADD_T1: begin
        alu_x = t_q;
        alu_y = acc_num_q;
      end
      ST_ADD_Q2: begin
        alu_ctl.op = ALU_DIV;
        alu_x      = mag(d_q);
        alu_y      = mag(od_q);
      end
      ST_ADD_T2: begin
        alu_x = t_q;
        alu_y = on_q;
      end
      ST_RED_GCD: begin
        alu_ctl.op = ALU_GCD;
        alu_x      = mag(n_q);
        alu_y      = mag(d_q);
      end
      ST_RED_DN: begin
        alu_ctl.op = ALU_DIV;
        alu_x      = mag(n_q);
        alu_y      = g_q;
      end
      ST_RED_DD: begin
        alu_ctl.op = ALU_DIV;
        alu_x      = mag(d_q);
        alu_y      = g_q;
      end
      default: begin
        call_st = 1'b0;
      end
    endcase
    alu_ctl.start = call_st && !issued_q;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (s_axis_tuser_i) inside
            KIND_LOAD:          st_d = ST_RED_CHK;
            KIND_ADD, KIND_SUB: st_d = ST_ADD_GCD;
            KIND_MUL, KIND_DIV: st_d = ST_MUL_N;
            default:            st_d = ST_FINISH;
          endcase
        end
      end
      ST_MUL_N:    if (alu_done) st_d = ST_MUL_D;
      ST_MUL_D:    if (alu_done) st_d = ST_RED_CHK;
      ST_ADD_GCD:  if (alu_done) st_d = ST_ADD_DIV1;
      ST_ADD_DIV1: if (alu_done) st_d = ST_ADD_LCM;
      ST_ADD_LCM:  if (alu_done) st_d = ST_ADD_Q1;
      ST_ADD_Q1:   if (alu_done) st_d = ST_ADD_T1;
      ST_ADD_T1:   if (alu_done) st_d = ST_ADD_Q2;
      ST_ADD_Q2:   if (alu_done) st_d = ST_ADD_T2;
      ST_ADD_T2:   if (alu_done) st_d = ST_ADD_SUM;
      ST_ADD_SUM:  st_d = ST_RED_CHK;
      ST_RED_CHK:  st_d = (n_q == '0) ? ST_FINISH : ST_RED_GCD;
      ST_RED_GCD:  if (alu_done) st_d = ST_RED_DN;
      ST_RED_DN:   if (alu_done) st_d = ST_RED_DD;
      ST_RED_DD:   if (alu_done) st_d = ST_FINISH;
      ST_FINISH:   if (out_free) st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      issued_q  <= 1'b0;
      acc_num_q <= '0;
      acc_den_q <= W'(1);
      m_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (alu_done) begin
        issued_q <= 1'b0;
      end else if (alu_ctl.start) begin
        issued_q <= 1'b1;
      end
      if (st_q == ST_RED_CHK && n_q == '0) begin
        acc_num_q <= '0;
        acc_den_q <= W'(1);
      end
      if (st_q == ST_RED_DN && alu_done) begin
        acc_num_q <= n_q[W-1] ? alu_neg : alu_res;
      end
      if (st_q == ST_RED_DD && alu_done) begin
        acc_den_q <= d_q[W-1] ? alu_neg : alu_res;
      end
      if (st_q == ST_FINISH && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_FINISH && out_free) begin
      m_num_q <= out_num_ext[FIELD_W-1:0];
      m_den_q <= out_den_ext[FIELD_W-1:0];
    end
    if (s_fire) begin
      kind_q <= s_axis_tuser_i;
      on_q   <= in_num;
      od_q   <= in_den_fix;
      n_q    <= in_num;
      d_q    <= in_den_fix;
    end
    if (alu_done) begin
      case (st_q)
        ST_MUL_N:    n_q <= alu_res;
        ST_MUL_D:    d_q <= alu_res;
        ST_ADD_GCD:  g_q <= alu_res;
        ST_ADD_DIV1: t_q <= alu_res;
        ST_ADD_LCM:  d_q <= alu_res;
        ST_ADD_Q1:   t_q <= (d_q[W-1] != acc_den_q[W-1]) ? alu_neg : alu_res;
        ST_ADD_T1:   n_q <= alu_res;
        ST_ADD_Q2:   t_q <= (d_q[W-1] != od_q[W-1]) ? alu_neg : alu_res;
        ST_ADD_T2:   t_q <= alu_res;
        ST_RED_GCD:  g_q <= alu_res;
        default: begin
        end
      endcase
    end
    if (st_q == ST_ADD_SUM) begin
      n_q <= (kind_q == KIND_SUB) ? (n_q - t_q) : (n_q + t_q);
    end
    if (st_q == ST_RED_CHK && (n_q == '0 || d_q == '0)) begin
      d_q <= W'(1);
    end
  end

endmodule

// File: hw/rtl/rau_alu.sv
// Shared iterative unit of the rational accumulator: product modulo 2^W, unsigned
// quotient and binary gcd, all on one adder, one step per cycle.
// Depends on rau_pkg.
module rau_alu import rau_pkg::*; #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  alu_ctl_t              ctl_i,
  input  logic [WORD_WIDTH-1:0] x_i,
  input  logic [WORD_WIDTH-1:0] y_i,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] res_o
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned CW = $clog2(W);

  alu_st_e       st_q, st_d;
  alu_op_e       op_q;
  logic [W-1:0]  a_q, b_q, r_q;
  logic [CW-1:0] cnt_q, k_q;

  logic [W-1:0]  opa, opb;
  logic          sub;
  logic [W:0]    sum;
  logic          carry, diff_zero;

  assign sum       = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (W+1)'(sub);
  assign carry     = sum[W];
  assign diff_zero = (sum[W-1:0] == '0);

  always_comb begin
    opa    = a_q;
    opb    = b_q;
    sub    = 1'b0;
    done_o = 1'b0;
    unique case (st_q)
      A_MUL: begin
        opa = {r_q[W-2:0], 1'b0};
        opb = b_q[W-1] ? a_q : '0;
      end
      A_DIV: begin
        opa = {r_q[W-2:0], a_q[W-1]};
        sub = 1'b1;
      end
      A_GCD: begin
        sub = 1'b1;
      end
      A_DONE: begin
        done_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_o = (op_q == ALU_MUL) ? r_q : a_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      A_IDLE: begin
        if (ctl_i.start) begin
          unique case (ctl_i.op)
            ALU_MUL: st_d = A_MUL;
            ALU_DIV: st_d = A_DIV;
            default: st_d = A_GCD;
          endcase
        end
      end
      A_MUL, A_DIV: begin
        if (cnt_q == '0) st_d = A_DONE;
      end
      A_GCD: begin
        if (diff_zero) st_d = A_GSHL;
      end
      A_GSHL: begin
        if (k_q == '0) st_d = A_DONE;
      end
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= A_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      A_IDLE: begin
        if (ctl_i.start) begin
          op_q  <= ctl_i.op;
          a_q   <= x_i;
          b_q   <= y_i;
          r_q   <= '0;
          cnt_q <= CW'(W - 1);
          k_q   <= '0;
        end
      end
      A_MUL: begin
        r_q   <= sum[W-1:0];
        b_q   <= {b_q[W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      A_DIV: begin
        r_q   <= carry ? sum[W-1:0] : opa;
        a_q   <= {a_q[W-2:0], carry};
        cnt_q <= cnt_q - 1'b1;
      end
      A_GCD: begin
        if (diff_zero) begin
        end else if (!a_q[0] && !b_q[0]) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (carry) begin
          a_q <= sum[W-1:0];
        end else begin
          a_q <= b_q;
          b_q <= a_q;
        end
      end
      A_GSHL: begin
        if (k_q != '0) begin
          a_q <= a_q << 1;
          k_q <= k_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: verif/tb_rational_accumulator_unit.sv
// Self-checking testbench for rational_accumulator_unit, built on rau_pkg.
// A fraction predictor computes the reduced accumulator for every accepted input transfer;
// each output transfer is compared against it under random sender gaps and receiver stalls.
module tb_rational_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  typedef logic [FIELD_W-1:0] word_t;

  typedef struct packed {
    word_t num;
    word_t den;
  } fraction_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

  localparam word_t WORD_MAX = 32'h7FFF_FFFF;
  localparam word_t WORD_MIN = 32'h8000_0000;

  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_ITEMS = 830;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [2*FIELD_W-1:0] s_axis_tdata = '0;
  logic [KIND_W-1:0]    s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*FIELD_W-1:0] m_axis_tdata;

  word_t     frac_num = '0;
  word_t     frac_den = 32'd1;
  fraction_t expected_fractions[$];
  int        error_count = 0;
  int        burst_left = 0;

  int        hold_req = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        rx_cycle = 0;
  int        rx_mode_left = 0;
  rx_mode_e  rx_mode = RX_OPEN;

  rational_accumulator_unit #(
    .WORD_WIDTH(FIELD_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic word_t word_mag(word_t x);
    return x[FIELD_W-1] ? -x : x;
  endfunction

  function automatic word_t word_div(word_t a, word_t b);
    word_t q;
    q = word_mag(a) / word_mag(b);
    return (a[FIELD_W-1] != b[FIELD_W-1]) ? -q : q;
  endfunction

  function automatic word_t mag_gcd(word_t a, word_t b);
    word_t t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic void store_reduced(word_t num, word_t den);
    word_t g;
    word_t n;
    word_t d;
    if (num == 0 || den == 0) den = 32'd1;
    if (num != 0) begin
      g = mag_gcd(word_mag(num), word_mag(den));
      n = word_mag(num) / g;
      d = word_mag(den) / g;
      num = num[FIELD_W-1] ? -n : n;
      den = den[FIELD_W-1] ? -d : d;
    end
    frac_num = num;
    frac_den = den;
  endfunction

  function automatic fraction_t fraction_apply(logic [KIND_W-1:0] kind, word_t on, word_t od);
    word_t     ma;
    word_t     mb;
    word_t     g;
    word_t     l;
    word_t     t1;
    word_t     t2;
    fraction_t res;
    if (kind <= KIND_SUB && od == 0) od = 32'd1;
    case (kind) inside
      KIND_LOAD: begin
        store_reduced(on, od);
      end
      KIND_ADD, KIND_SUB: begin
        ma = word_mag(frac_den);
        mb = word_mag(od);
        g  = mag_gcd(ma, mb);
        l  = (ma / g) * mb;
        t1 = word_div(l, frac_den) * frac_num;
        t2 = word_div(l, od) * on;
        store_reduced((kind == KIND_ADD) ? t1 + t2 : t1 - t2, l);
      end
      KIND_MUL: begin
        store_reduced(frac_num * on, frac_den * od);
      end
      KIND_DIV: begin
        store_reduced(frac_num * od, frac_den * on);
      end
      default: begin
      end
    endcase
    res.num = frac_num;
    res.den = frac_den;
    return res;
  endfunction

  task automatic send_item(logic [KIND_W-1:0] kind, word_t num, word_t den);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      case ($urandom_range(0, 9)) inside
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 400);
        default: gap = $urandom_range(1, 15);
      endcase
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {den, num};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_fractions.push_back(fraction_apply(kind, num, den));
  endtask

  function automatic word_t random_operand();
    case ($urandom_range(0, 9)) inside
      0, 1, 2, 3, 4: return word_t'($urandom_range(0, 40)) - 32'd20;
      5, 6:          return word_t'($urandom_range(0, 2000)) - 32'd1000;
      7:             return $urandom();
      8: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return 32'd1;
          2:       return '1;
          3:       return WORD_MAX;
          4:       return WORD_MIN;
          default: return 32'd2;
        endcase
      end
      default: return (word_t'(1) << $urandom_range(0, 31)) * ($urandom_range(0, 1) ? 1 : -1);
    endcase
  endfunction

  function automatic word_t random_den();
    return ($urandom_range(0, 9) < 3) ? 32'd1 : random_operand();
  endfunction

  function automatic logic [KIND_W-1:0] random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return KIND_LOAD;
    if (r < 35) return KIND_ADD;
    if (r < 55) return KIND_SUB;
    if (r < 75) return KIND_MUL;
    if (r < 95) return KIND_DIV;
    case ($urandom_range(0, 2))
      0:       return KIND_RSVD5;
      1:       return KIND_RSVD6;
      default: return KIND_RSVD7;
    endcase
  endfunction

  task automatic test_load_extremes();
    send_item(KIND_LOAD, WORD_MAX, WORD_MIN);
    send_item(KIND_LOAD, WORD_MIN, -1);
    send_item(KIND_LOAD, 0, 7);
    send_item(KIND_LOAD, 12, 0);
    send_item(KIND_LOAD, 6, -4);
    send_item(KIND_LOAD, -18, -12);
  endtask

  task automatic test_arith_ops();
    send_item(KIND_ADD, 1, 3);
    send_item(KIND_SUB, 5, 1);
    send_item(KIND_MUL, -2, 7);
    send_item(KIND_DIV, 3, -5);
    send_item(KIND_ADD, 7, 0);
    send_item(KIND_SUB, 3, WORD_MIN);
  endtask

  task automatic test_zero_products();
    send_item(KIND_MUL, 0, 1);
    send_item(KIND_LOAD, 5, 3);
    send_item(KIND_MUL, 2, 0);
    send_item(KIND_LOAD, 5, 3);
    send_item(KIND_DIV, 0, 4);
  endtask

  // The common denominator and the products overflow the word here, and the most
  // negative value is divided by minus one inside the common-denominator step.
  task automatic test_wrapping();
    send_item(KIND_LOAD, 5, -1);
    send_item(KIND_ADD, 1, WORD_MIN);
    send_item(KIND_LOAD, 1, 65537);
    send_item(KIND_ADD, 1, 65521);
    send_item(KIND_LOAD, 100003, 7);
    send_item(KIND_MUL, WORD_MAX, 99991);
    send_item(KIND_DIV, WORD_MAX, WORD_MAX);
  endtask

  task automatic test_reserved_kinds();
    send_item(KIND_RSVD5, '1, '1);
    send_item(KIND_RSVD6, WORD_MIN, 0);
    send_item(KIND_RSVD7, WORD_MAX, 1);
  endtask

  // The receiver holds off while the sender keeps offering back to back, so the
  // output register fills and the input side has to stall.
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    burst_left = 12;
    repeat (12) send_item(random_kind(), random_operand(), random_den());
  endtask

  task automatic test_random();
    repeat (RANDOM_ITEMS) send_item(random_kind(), random_operand(), random_den());
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(50, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      rx_cycle <= rx_cycle + 1;
      case (rx_mode)
        RX_OPEN:     m_axis_tready <= 1'b1;
        RX_RANDOM:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: m_axis_tready <= (rx_cycle % 5) < 3;
        default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    fraction_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_fractions.size() == 0) begin
        $display("%0t: unexpected result, got %0d / %0d", $time,
                 $signed(m_axis_tdata[FIELD_W-1:0]), $signed(m_axis_tdata[2*FIELD_W-1:FIELD_W]));
        error_count++;
      end else begin
        want = expected_fractions.pop_front();
        if (m_axis_tdata[FIELD_W-1:0] !== want.num) begin
          $display("%0t: result_num expected %0d, got %0d", $time,
                   $signed(want.num), $signed(m_axis_tdata[FIELD_W-1:0]));
          error_count++;
        end
        if (m_axis_tdata[2*FIELD_W-1:FIELD_W] !== want.den) begin
          $display("%0t: result_den expected %0d, got %0d", $time,
                   $signed(want.den), $signed(m_axis_tdata[2*FIELD_W-1:FIELD_W]));
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_extremes();
    test_arith_ops();
    test_zero_products();
    test_wrapping();
    test_reserved_kinds();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
